@@ src/wtm_pkg.sv @@
// Shared types, constants and the control store for the windowed throughput meter.
// Depends on nothing; every other file of the meter but wtm_ram refers to it by scoped names.
`timescale 1ns / 1ps

package wtm_pkg;

    // Ring geometry; the ring index is the low bits of a bucket number,
    // so the ring depth stays a power of two
    localparam int BUCKETS  = 16;
    localparam int IDX_W    = $clog2(BUCKETS);
    localparam int WIDTH_W  = 5;

    // Field widths
    localparam int TICK_W   = 32;
    localparam int BYTE_W   = 32;
    localparam int MS_W     = 16;
    localparam int RATE_W   = 47;

    // Datapath widths: window sum, scaled sum, divider operands
    localparam int ACC_W    = BYTE_W + IDX_W;
    localparam int PROD_W   = ACC_W + 10;
    localparam int DVD_W    = 48;
    localparam int DVS_W    = 20;
    localparam int CNT_W    = $clog2(DVD_W + 1);
    localparam int RATE_SCALE = 1000;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_BUCKET_MS = '0;
    localparam logic [MS_W-1:0] BUCKET_MS_RESET = 16'd100;

    // Item actions
    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV_TICK,
        OP_SLIDE,
        OP_ADD_WR,
        OP_CLEAR,
        OP_SUM_INIT,
        OP_SUM_STEP,
        OP_SUM_LAST,
        OP_MUL,
        OP_DIV_RATE,
        OP_EMIT
    } uop_t;

    // Jump conditions
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_GO,
        CND_DIV_BUSY,
        CND_IS_QUERY,
        CND_IS_CLEAR,
        CND_SUM_MORE
    } cond_t;

    localparam int STEP_W = 4;

    // Control store addresses
    localparam logic [STEP_W-1:0] S_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] S_DIV_TICK  = 4'd1;
    localparam logic [STEP_W-1:0] S_TICK_WAIT = 4'd2;
    localparam logic [STEP_W-1:0] S_SLIDE     = 4'd3;
    localparam logic [STEP_W-1:0] S_RD_CUR    = 4'd4;
    localparam logic [STEP_W-1:0] S_ADD_WR    = 4'd5;
    localparam logic [STEP_W-1:0] S_CLEAR     = 4'd6;
    localparam logic [STEP_W-1:0] S_SUM_INIT  = 4'd7;
    localparam logic [STEP_W-1:0] S_SUM_STEP  = 4'd8;
    localparam logic [STEP_W-1:0] S_SUM_LAST  = 4'd9;
    localparam logic [STEP_W-1:0] S_MUL       = 4'd10;
    localparam logic [STEP_W-1:0] S_DIV_RATE  = 4'd11;
    localparam logic [STEP_W-1:0] S_RATE_WAIT = 4'd12;
    localparam logic [STEP_W-1:0] S_EMIT      = 4'd13;

    typedef struct packed {
        uop_t               op;
        cond_t              cond;
        logic [STEP_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        logic go;
        logic div_busy;
        logic is_query;
        logic is_clear;
        logic sum_more;
    } status_t;

    // Control store: one word per step, jump to target when cond holds
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            S_IDLE:      w = '{OP_NOP,      CND_NO_GO,    S_IDLE};
            S_DIV_TICK:  w = '{OP_DIV_TICK, CND_NEVER,    S_IDLE};
            S_TICK_WAIT: w = '{OP_NOP,      CND_DIV_BUSY, S_TICK_WAIT};
            S_SLIDE:     w = '{OP_SLIDE,    CND_IS_QUERY, S_SUM_INIT};
            // the current bucket is read here for add, harmless for clear
            S_RD_CUR:    w = '{OP_NOP,      CND_IS_CLEAR, S_CLEAR};
            S_ADD_WR:    w = '{OP_ADD_WR,   CND_ALWAYS,   S_IDLE};
            S_CLEAR:     w = '{OP_CLEAR,    CND_ALWAYS,   S_IDLE};
            S_SUM_INIT:  w = '{OP_SUM_INIT, CND_NEVER,    S_IDLE};
            S_SUM_STEP:  w = '{OP_SUM_STEP, CND_SUM_MORE, S_SUM_STEP};
            S_SUM_LAST:  w = '{OP_SUM_LAST, CND_NEVER,    S_IDLE};
            S_MUL:       w = '{OP_MUL,      CND_NEVER,    S_IDLE};
            S_DIV_RATE:  w = '{OP_DIV_RATE, CND_NEVER,    S_IDLE};
            S_RATE_WAIT: w = '{OP_NOP,      CND_DIV_BUSY, S_RATE_WAIT};
            S_EMIT:      w = '{OP_EMIT,     CND_ALWAYS,   S_IDLE};
            default:     w = '{OP_NOP,      CND_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/wtm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module wtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/wtm_divider.sv @@
// Bit-serial restoring divider: one quotient bit per clock, shared by the
// bucket index and the rate. Depends on wtm_pkg.
`timescale 1ns / 1ps

module wtm_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [wtm_pkg::DVD_W-1:0]   dividend,
    input  logic [wtm_pkg::DVS_W-1:0]   divisor,
    input  logic [wtm_pkg::CNT_W-1:0]   steps,
    output logic                        busy,
    output logic [wtm_pkg::DVD_W-1:0]   quotient
);

    logic [wtm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [wtm_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic [wtm_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [wtm_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [wtm_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [wtm_pkg::DVS_W:0]   rem_shift;
    logic [wtm_pkg::DVS_W:0]   diff;
    logic                      take;

    // Shift in the next dividend bit and try to subtract the divisor
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[wtm_pkg::DVD_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        take      = ~diff[wtm_pkg::DVS_W];
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (load)
        begin
            cnt_next = steps;
            dvd_next = dividend;
            dvs_next = divisor;
            quo_next = '0;
            rem_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[wtm_pkg::DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[wtm_pkg::DVD_W-2:0], take};
            rem_next = take ? diff[wtm_pkg::DVS_W-1:0] : rem_shift[wtm_pkg::DVS_W-1:0];
        end
    end

    // Hold the step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Advance the operands
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

@@ src/wtm_sequencer.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on wtm_pkg.
`timescale 1ns / 1ps

module wtm_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  wtm_pkg::status_t status,
    output wtm_pkg::ucode_t  ctrl,
    output logic             busy
);

    logic [wtm_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       taken;

    // Fetch the control word and pick the next step
    always_comb
    begin
        ctrl = wtm_pkg::ucode_rom(step_reg);
        case (ctrl.cond)
            wtm_pkg::CND_NEVER:    taken = 1'b0;
            wtm_pkg::CND_ALWAYS:   taken = 1'b1;
            wtm_pkg::CND_NO_GO:    taken = ~status.go;
            wtm_pkg::CND_DIV_BUSY: taken = status.div_busy;
            wtm_pkg::CND_IS_QUERY: taken = status.is_query;
            wtm_pkg::CND_IS_CLEAR: taken = status.is_clear;
            wtm_pkg::CND_SUM_MORE: taken = status.sum_more;
            default:               taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : step_reg + 1'b1;
    end

    // Hold the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= wtm_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign busy = (step_reg != wtm_pkg::S_IDLE);

endmodule

@@ src/wtm_datapath.sv @@
// Meter datapath: window bounds, bucket ring with valid bits, window sum,
// scaling and the shared divider. Depends on wtm_pkg, wtm_ram, wtm_divider.
`timescale 1ns / 1ps

module wtm_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         accept,
    input  logic [1:0]                   action,
    input  logic [wtm_pkg::TICK_W-1:0]   tick_ms,
    input  logic [wtm_pkg::BYTE_W-1:0]   byte_count,
    input  logic [wtm_pkg::MS_W-1:0]     bucket_ms,
    input  wtm_pkg::ucode_t              ctrl,
    output wtm_pkg::status_t             status,
    output logic [wtm_pkg::RATE_W-1:0]   rate_bytes_per_s,
    output logic [wtm_pkg::WIDTH_W-1:0]  window_buckets,
    output logic                         done
);

    // Control state
    logic [wtm_pkg::TICK_W-1:0]  first_reg, first_next;
    logic [wtm_pkg::TICK_W-1:0]  end_reg, end_next;
    logic [wtm_pkg::BUCKETS-1:0] valid_reg, valid_next;
    logic                        done_reg, done_next;

    // Payload
    wtm_pkg::action_t            action_reg, action_next;
    logic [wtm_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [wtm_pkg::BYTE_W-1:0]  bytes_reg, bytes_next;
    logic [wtm_pkg::TICK_W-1:0]  cur_reg, cur_next;
    logic [wtm_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [wtm_pkg::IDX_W-1:0]   ptr_reg, ptr_next;
    logic [wtm_pkg::WIDTH_W-1:0] left_reg, left_next;
    logic                        pend_reg, pend_next;
    logic [wtm_pkg::WIDTH_W-1:0] width_reg, width_next;
    logic [wtm_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [wtm_pkg::DVS_W-1:0]   den_reg, den_next;
    logic                        rd_valid_reg;
    logic [wtm_pkg::RATE_W-1:0]  rate_reg, rate_next;
    logic [wtm_pkg::WIDTH_W-1:0] wb_reg, wb_next;

    // Window arithmetic
    logic [wtm_pkg::MS_W-1:0]    len;
    logic [wtm_pkg::TICK_W-1:0]  cur_raw, cur_cap, end_m1, cur_new, skipped, end_new;
    logic [wtm_pkg::WIDTH_W-1:0] n_skip;
    logic [wtm_pkg::BUCKETS-1:0] skip_mask;
    logic [wtm_pkg::TICK_W-1:0]  span;

    // Ring and divider
    logic                        ram_we;
    logic [wtm_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [wtm_pkg::BYTE_W-1:0]  ram_wdata, ram_rdata, rd_bytes;
    logic                        div_load, div_busy;
    logic [wtm_pkg::DVD_W-1:0]   div_dividend, div_quo;
    logic [wtm_pkg::DVS_W-1:0]   div_divisor;
    logic [wtm_pkg::CNT_W-1:0]   div_steps;

    // A bucket length of zero counts as one
    assign len = (bucket_ms == '0) ? wtm_pkg::MS_W'(1) : bucket_ms;

    // Bucket index clamp, skipped-bucket mask and window slide
    always_comb
    begin
        cur_raw = div_quo[wtm_pkg::TICK_W-1:0];
        cur_cap = (cur_raw == '1) ? cur_raw - 1'b1 : cur_raw;
        end_m1  = end_reg - 1'b1;
        cur_new = (cur_cap < end_m1) ? end_m1 : cur_cap;
        skipped = cur_new - end_m1;
        n_skip  = (skipped < wtm_pkg::TICK_W'(wtm_pkg::BUCKETS)) ?
                  skipped[wtm_pkg::WIDTH_W-1:0] : wtm_pkg::WIDTH_W'(wtm_pkg::BUCKETS);
        end_new = cur_new + 1'b1;
        for (int j = 0; j < wtm_pkg::BUCKETS; j++)
        begin
            skip_mask[j] = ({1'b0, wtm_pkg::IDX_W'(j) - end_reg[wtm_pkg::IDX_W-1:0]} < n_skip);
        end
    end

    assign span = end_reg - first_reg;

    // Read data of a bucket not written since its valid bit was last cleared (by a clear or a slide) counts as zero
    assign rd_bytes  = rd_valid_reg ? ram_rdata : '0;
    assign ram_raddr = (ctrl.op == wtm_pkg::OP_SUM_STEP) ? ptr_reg
                                                         : cur_reg[wtm_pkg::IDX_W-1:0];
    assign ram_we    = (ctrl.op == wtm_pkg::OP_ADD_WR);
    assign ram_waddr = cur_reg[wtm_pkg::IDX_W-1:0];
    assign ram_wdata = rd_bytes + bytes_reg;

    // Divider operands: bucket index, then rate
    always_comb
    begin
        div_load = 1'b0;
        div_dividend = {tick_reg, {(wtm_pkg::DVD_W - wtm_pkg::TICK_W){1'b0}}};
        div_divisor  = wtm_pkg::DVS_W'(len);
        div_steps    = wtm_pkg::CNT_W'(wtm_pkg::TICK_W);
        case (ctrl.op)
            wtm_pkg::OP_DIV_TICK:
            begin
                div_load = 1'b1;
            end
            wtm_pkg::OP_DIV_RATE:
            begin
                div_load     = 1'b1;
                div_dividend = wtm_pkg::DVD_W'(prod_reg);
                div_divisor  = den_reg;
                div_steps    = wtm_pkg::CNT_W'(wtm_pkg::DVD_W);
            end
            default:
            begin
                div_load = 1'b0;
            end
        endcase
    end

    // Next values per micro-operation
    always_comb
    begin
        first_next  = first_reg;
        end_next    = end_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        action_next = action_reg;
        tick_next   = tick_reg;
        bytes_next  = bytes_reg;
        cur_next    = cur_reg;
        acc_next    = acc_reg;
        ptr_next    = ptr_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        width_next  = width_reg;
        prod_next   = prod_reg;
        den_next    = den_reg;
        rate_next   = rate_reg;
        wb_next     = wb_reg;

        if (accept)
        begin
            action_next = wtm_pkg::action_t'(action);
            tick_next   = tick_ms;
            bytes_next  = byte_count;
        end

        case (ctrl.op)
            wtm_pkg::OP_SLIDE:
            begin
                cur_next   = cur_new;
                end_next   = end_new;
                valid_next = valid_reg & ~skip_mask;
                if (end_new >= wtm_pkg::TICK_W'(wtm_pkg::BUCKETS) &&
                    first_reg < end_new - wtm_pkg::TICK_W'(wtm_pkg::BUCKETS))
                begin
                    first_next = end_new - wtm_pkg::TICK_W'(wtm_pkg::BUCKETS);
                end
            end
            wtm_pkg::OP_ADD_WR:
            begin
                valid_next[cur_reg[wtm_pkg::IDX_W-1:0]] = 1'b1;
            end
            wtm_pkg::OP_CLEAR:
            begin
                valid_next = '0;
                first_next = cur_reg;
            end
            wtm_pkg::OP_SUM_INIT:
            begin
                acc_next   = '0;
                ptr_next   = first_reg[wtm_pkg::IDX_W-1:0];
                left_next  = span[wtm_pkg::WIDTH_W-1:0];
                width_next = span[wtm_pkg::WIDTH_W-1:0];
                pend_next  = 1'b0;
            end
            wtm_pkg::OP_SUM_STEP:
            begin
                // read one bucket, add the one read on the previous step
                ptr_next  = ptr_reg + 1'b1;
                left_next = left_reg - 1'b1;
                pend_next = 1'b1;
                acc_next  = acc_reg + (pend_reg ? wtm_pkg::ACC_W'(rd_bytes) : '0);
            end
            wtm_pkg::OP_SUM_LAST:
            begin
                acc_next = acc_reg + wtm_pkg::ACC_W'(rd_bytes);
            end
            wtm_pkg::OP_MUL:
            begin
                prod_next = wtm_pkg::PROD_W'(acc_reg) * wtm_pkg::PROD_W'(wtm_pkg::RATE_SCALE);
                den_next  = wtm_pkg::DVS_W'(width_reg) * wtm_pkg::DVS_W'(len);
            end
            wtm_pkg::OP_EMIT:
            begin
                rate_next = div_quo[wtm_pkg::RATE_W-1:0];
                wb_next   = width_reg;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Hold window bounds, valid bits and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            end_reg   <= wtm_pkg::TICK_W'(1);
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            first_reg <= first_next;
            end_reg   <= end_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Advance the payload registers
    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        tick_reg     <= tick_next;
        bytes_reg    <= bytes_next;
        cur_reg      <= cur_next;
        acc_reg      <= acc_next;
        ptr_reg      <= ptr_next;
        left_reg     <= left_next;
        pend_reg     <= pend_next;
        width_reg    <= width_next;
        prod_reg     <= prod_next;
        den_reg      <= den_next;
        rd_valid_reg <= valid_reg[ram_raddr];
        rate_reg     <= rate_next;
        wb_reg       <= wb_next;
    end

    wtm_ram #(
        .WIDTH (wtm_pkg::BYTE_W),
        .DEPTH (wtm_pkg::BUCKETS)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wtm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Status for the sequencer
    always_comb
    begin
        status.go       = start && (action != wtm_pkg::ACT_NONE);
        status.div_busy = div_busy;
        status.is_query = (action_reg == wtm_pkg::ACT_QUERY);
        status.is_clear = (action_reg == wtm_pkg::ACT_CLEAR);
        status.sum_more = (left_reg != wtm_pkg::WIDTH_W'(1));
    end

    assign rate_bytes_per_s = rate_reg;
    assign window_buckets   = wb_reg;
    assign done             = done_reg;

endmodule

@@ src/windowed_throughput_meter.sv @@
// Add and clear keep busy high while they run, an unused action leaves busy low;
// a query ends in a done strobe, and its run grows with W (window buckets, 1..16).
// The bit-serial divider (one quotient bit per cycle: 32 bits for the bucket index,
// 48 for the rate) and the one-bucket-per-cycle window sum set the length of each run.
// Throughput: one transaction at a time; start is taken whenever busy is low.
// Reset (rst_n, async, active low): empty ring, window 0..1, bucket_ms 100.
`timescale 1ns / 1ps

module windowed_throughput_meter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      action,
    input  logic [wtm_pkg::TICK_W-1:0]      tick_ms,
    input  logic [wtm_pkg::BYTE_W-1:0]      byte_count,
    output logic [wtm_pkg::RATE_W-1:0]      rate_bytes_per_s,
    output logic [wtm_pkg::WIDTH_W-1:0]     window_buckets,
    output logic                            done,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wtm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [wtm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [wtm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [wtm_pkg::MS_W-1:0] bucket_ms_reg, bucket_ms_next;
    logic                     reg_hit;
    logic                     cfg_write;
    logic                     accept;
    wtm_pkg::ucode_t          ctrl;
    wtm_pkg::status_t         status;

    // Register decode
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[wtm_pkg::CFG_ADDR_W-1:2] == wtm_pkg::REG_BUCKET_MS);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_hit ? wtm_pkg::CFG_DATA_W'(bucket_ms_reg) : '0;

    always_comb
    begin
        bucket_ms_next = bucket_ms_reg;
        if (cfg_write && reg_hit)
        begin
            bucket_ms_next = pwdata[wtm_pkg::MS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_ms_reg <= wtm_pkg::BUCKET_MS_RESET;
        end
        else
        begin
            bucket_ms_reg <= bucket_ms_next;
        end
    end

    // Take a transaction while the sequencer sits idle
    assign accept = start && !busy;

    wtm_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    wtm_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .accept           (accept),
        .action           (action),
        .tick_ms          (tick_ms),
        .byte_count       (byte_count),
        .bucket_ms        (bucket_ms_reg),
        .ctrl             (ctrl),
        .status           (status),
        .rate_bytes_per_s (rate_bytes_per_s),
        .window_buckets   (window_buckets),
        .done             (done)
    );

endmodule

@@ src/wtm_checker.sv @@
// Port-level checks for the windowed throughput meter, bound to the top level.
// Depends on wtm_pkg and windowed_throughput_meter.
`timescale 1ns / 1ps

module wtm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [1:0]                      action,
    input logic [wtm_pkg::WIDTH_W-1:0]     window_buckets,
    input logic                            done
);

    // A result closes a query: it follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // One result per query transaction
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // A reported window covers one to BUCKETS buckets
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (window_buckets != '0 &&
                  window_buckets <= wtm_pkg::WIDTH_W'(wtm_pkg::BUCKETS)))
        else $error("window bucket count out of range");

    // A query transaction starts the sequencer
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == wtm_pkg::ACT_QUERY) |=> busy)
        else $error("query transaction did not raise busy");

endmodule

bind windowed_throughput_meter wtm_checker u_wtm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .window_buckets (window_buckets),
    .done           (done)
);
